[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions on aclk and aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

[hdl/apq_pkg.sv]
// ----------------------------------------------------------------------------
// Array priority queue package
// Sizes, request and status codes, and the stored entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package apq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int FILL_W = 7;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } store_req_t;

endpackage

`default_nettype wire

[hdl/apq_store.sv]
// ----------------------------------------------------------------------------
// Array priority queue entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module apq_store (
    input  wire logic                aclk,
    input  wire apq_pkg::store_req_t req,
    output apq_pkg::entry_t          rd_data
);
    import apq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/array_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Array priority queue
// Unsorted array of entries in arrival order, served largest priority first.
//
// Channel | Direction | tdata (low bit up)                  | tuser
// s_      | in        | data_in[31:0], prio_in[39:32]       | req_type[1:0]
// m_      | out       | data_out[31:0], fill_level[38:32]   | status[1:0]
//
// Enqueue, overflow, underflow and no-op go straight from accept to the response state.
// Peek scans the held entries with one read of the entry store per held entry.
// Dequeue runs the same scan, then does one store read and write per later
// entry to close the gap.
// Reset clears the state, the count and the output valid; the store needs no
// clearing.
// A new transaction is taken only once the previous result has been loaded
// into the output register; a stalled output holds the next result back.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [apq_pkg::S_TDATA_W-1:0]  s_tdata,  // data_in, prio_in
    input  wire logic [apq_pkg::REQ_W-1:0]      s_tuser,  // req_type
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [apq_pkg::M_TDATA_W-1:0]       m_tdata,  // data_out, fill_level
    output logic [apq_pkg::STAT_W-1:0]          m_tuser   // status
);
    import apq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [IDX_W-1:0]    chk_reg, chk_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [PRIO_W-1:0]   best_prio_reg, best_prio_next;
    logic [DATA_W-1:0]   best_data_reg, best_data_next;
    logic [IDX_W-1:0]    shift_wr_reg, shift_wr_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    status_t             res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]   m_tuser_reg, m_tuser_next;

    store_req_t          store_req;
    entry_t              rd_data;

    logic                s_accept;
    logic                take;
    logic [IDX_W-1:0]    sel_idx;
    logic [DATA_W-1:0]   sel_data;
    logic [CNT_W-1:0]    shift_rd;
    logic [CNT_W-1:0]    last_idx;
    logic                out_free;

    apq_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_idx = count_reg - CNT_W'(1);
    assign take     = (chk_reg == '0) || (rd_data.prio > best_prio_reg);
    assign sel_idx  = take ? chk_reg : best_idx_reg;
    assign sel_data = take ? rd_data.data : best_data_reg;
    assign shift_rd = CNT_W'(shift_wr_reg) + CNT_W'(2);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        issue_next      = issue_reg;
        chk_next        = chk_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_data_next  = best_data_reg;
        shift_wr_next   = shift_wr_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        store_req       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next        = s_tuser;
                    res_data_next   = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESP;
                    case (s_tuser)
                        REQ_ENQ: begin
                            if (count_reg >= CNT_W'(DEPTH)) begin
                                res_status_next = ST_OVERFLOW;
                            end else begin
                                store_req.wr_en        = 1'b1;
                                store_req.wr_addr      = count_reg[IDX_W-1:0];
                                store_req.wr_data.data = s_tdata[DATA_W-1:0];
                                store_req.wr_data.prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];
                                count_next             = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DEQ, REQ_PEEK: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_UNDERFLOW;
                            end else begin
                                store_req.rd_en   = 1'b1;
                                store_req.rd_addr = '0;
                                issue_next        = CNT_W'(1);
                                chk_next          = '0;
                                state_next        = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                best_idx_next  = sel_idx;
                best_prio_next = take ? rd_data.prio : best_prio_reg;
                best_data_next = sel_data;
                chk_next       = chk_reg + IDX_W'(1);
                if (issue_reg < count_reg) begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = issue_reg[IDX_W-1:0];
                    issue_next        = issue_reg + CNT_W'(1);
                end
                if (CNT_W'(chk_reg) == last_idx) begin
                    res_data_next   = sel_data;
                    res_status_next = ST_OK;
                    if (req_reg == REQ_PEEK) begin
                        state_next = S_RESP;
                    end else if (CNT_W'(sel_idx) == last_idx) begin
                        count_next = last_idx;
                        state_next = S_RESP;
                    end else begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = sel_idx + IDX_W'(1);
                        shift_wr_next     = sel_idx;
                        state_next        = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = shift_wr_reg;
                store_req.wr_data = rd_data;
                shift_wr_next     = shift_wr_reg + IDX_W'(1);
                if (shift_rd < count_reg) begin
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = shift_rd[IDX_W-1:0];
                end
                if (CNT_W'(shift_wr_reg) + CNT_W'(1) == last_idx) begin
                    count_next = last_idx;
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({FILL_W'(count_reg), res_data_reg});
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        req_reg        <= req_next;
        issue_reg      <= issue_next;
        chk_reg        <= chk_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_data_reg  <= best_data_next;
        shift_wr_reg   <= shift_wr_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(DEPTH), "entry count above depth")
    `ASSERT_CLK(a_enq_count,
        (s_accept && s_tuser == REQ_ENQ && count_reg < CNT_W'(DEPTH))
            |=> (count_reg == $past(count_reg) + CNT_W'(1)),
        "enqueue did not advance the count")
    `ASSERT_CLK(a_shift_range,
        (state_reg == S_SHIFT) |-> (CNT_W'(shift_wr_reg) + CNT_W'(1) < count_reg),
        "gap close ran past the held entries")
    `ASSERT_CLK(a_out_load, $rose(m_tvalid_reg) |-> $past(state_reg == S_RESP),
        "result presented outside the response state")

endmodule

`default_nettype wire

[tb/array_priority_queue_top_tb.sv]
// ----------------------------------------------------------------------------
// Array priority queue testbench
// Drives enqueue, dequeue, peek and unused requests into the block and checks
// every result against a behavioral copy of the queue: a directed part on the
// field extremes, ties, empty and full stores, a fill-and-drain pass, and
// random request mixes under several idling and stalling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module array_priority_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_TICKS = 2 * DEPTH + 64;

    typedef struct {
        logic [DATA_W-1:0] data;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } queue_reply_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    logic [DATA_W-1:0] held_data [DEPTH];
    logic [PRIO_W-1:0] held_prio [DEPTH];
    int                held_count;

    queue_reply_t predicted_replies [$];
    queue_reply_t oldest_reply;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int errors          = 0;
    int cycles          = 0;
    int sent_count      = 0;
    int checked_count   = 0;
    int overflow_count  = 0;
    int underflow_count = 0;
    int peak_fill       = 0;

    array_priority_queue_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("cycle %0d: %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
        errors++;
    endtask

    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] din,
                                   input logic [PRIO_W-1:0] pin);
        queue_reply_t reply;
        int           best;
        reply.data   = '0;
        reply.status = ST_OK;
        case (req)
            REQ_ENQ: begin
                if (held_count >= DEPTH) begin
                    reply.status = ST_OVERFLOW;
                end else begin
                    held_data[IDX_W'(held_count)] = din;
                    held_prio[IDX_W'(held_count)] = pin;
                    held_count++;
                end
            end
            REQ_DEQ, REQ_PEEK: begin
                if (held_count == 0) begin
                    reply.status = ST_UNDERFLOW;
                end else begin
                    best = 0;
                    for (int i = 1; i < held_count; i++) begin
                        if (held_prio[IDX_W'(i)] > held_prio[IDX_W'(best)]) best = i;
                    end
                    reply.data = held_data[IDX_W'(best)];
                    if (req == REQ_DEQ) begin
                        for (int i = best; i + 1 < held_count; i++) begin
                            held_data[IDX_W'(i)] = held_data[IDX_W'(i + 1)];
                            held_prio[IDX_W'(i)] = held_prio[IDX_W'(i + 1)];
                        end
                        held_count--;
                    end
                end
            end
            default: ;
        endcase
        reply.fill = held_count[FILL_W-1:0];
        if (reply.status == ST_OVERFLOW) overflow_count++;
        if (reply.status == ST_UNDERFLOW) underflow_count++;
        if (held_count > peak_fill) peak_fill = held_count;
        predicted_replies.push_back(reply);
    endtask

    // Call only right after a rising edge; returns right after the accepting edge.
    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] din,
                                 input logic [PRIO_W-1:0] pin);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pin, din};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        predict_request(req, din, pin);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("result transaction with none expected", m_tdata[DATA_W-1:0], '0);
            end else begin
                oldest_reply = predicted_replies.pop_front();
                checked_count++;
                if (m_tdata[DATA_W-1:0] !== oldest_reply.data)
                    report_mismatch("data_out", m_tdata[DATA_W-1:0], oldest_reply.data);
                if (m_tdata[DATA_W+FILL_W-1:DATA_W] !== oldest_reply.fill)
                    report_mismatch("fill_level", DATA_W'(m_tdata[DATA_W+FILL_W-1:DATA_W]),
                                    DATA_W'(oldest_reply.fill));
                if (m_tdata[M_TDATA_W-1:DATA_W+FILL_W] !== '0)
                    report_mismatch("tdata padding",
                                    DATA_W'(m_tdata[M_TDATA_W-1:DATA_W+FILL_W]), '0);
                if (m_tuser !== oldest_reply.status)
                    report_mismatch("status", DATA_W'(m_tuser), DATA_W'(oldest_reply.status));
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0:       return PRIO_W'($urandom_range(3));
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return PRIO_W'($urandom_range(255));
        endcase
    endfunction

    task automatic test_directed_basics();
        issue_request(REQ_DEQ, 32'h1234_5678, 8'hFF);
        issue_request(REQ_PEEK, 32'h0, 8'h0);
        issue_request(REQ_NOP, 32'hFFFF_FFFF, 8'hFF);
        issue_request(REQ_ENQ, 32'h7FFF_FFFF, 8'h00);
        issue_request(REQ_ENQ, 32'h8000_0000, 8'hFF);
        issue_request(REQ_ENQ, 32'hFFFF_FFFF, 8'hFF);
        issue_request(REQ_ENQ, 32'h0000_0000, 8'h80);
        issue_request(REQ_ENQ, 32'h5555_AAAA, 8'h00);
        issue_request(REQ_PEEK, 32'hFFFF_FFFF, 8'h00);
        issue_request(REQ_NOP, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_PEEK, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_PEEK, 32'h0, 8'h0);
    endtask

    task automatic test_full_and_drain();
        for (int i = 0; i < DEPTH; i++) issue_request(REQ_ENQ, pick_data(), pick_prio());
        issue_request(REQ_PEEK, 32'h0, 8'h0);
        for (int i = 0; i < 3; i++) issue_request(REQ_ENQ, pick_data(), pick_prio());
        issue_request(REQ_DEQ, 32'h0, 8'h0);
        issue_request(REQ_ENQ, 32'h8000_0000, 8'hFF);
        issue_request(REQ_ENQ, 32'h7FFF_FFFF, 8'h00);
        while (held_count > 0)
            issue_request(REQ_DEQ, $urandom, PRIO_W'($urandom_range(255)));
        issue_request(REQ_DEQ, 32'h0, 8'h0);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_rate);
        int enq_pct;
        int run_left;
        int roll;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_rate;
        run_left        = 0;
        enq_pct         = 50;
        for (int n = 0; n < n_items; n++) begin
            if (run_left == 0) begin
                case ($urandom_range(2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 25;
                    default: enq_pct = 50;
                endcase
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            roll = $urandom_range(99);
            if (roll < 4)
                issue_request(REQ_NOP, $urandom, PRIO_W'($urandom_range(255)));
            else if ($urandom_range(99) < enq_pct)
                issue_request(REQ_ENQ, pick_data(), pick_prio());
            else if ($urandom_range(3) == 0)
                issue_request(REQ_PEEK, $urandom, PRIO_W'($urandom_range(255)));
            else
                issue_request(REQ_DEQ, $urandom, PRIO_W'($urandom_range(255)));
        end
    endtask

    initial begin
        held_count = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_basics();
        test_full_and_drain();
        test_random_traffic(225, 0, 0);
        test_random_traffic(225, 54, 0);
        test_random_traffic(225, 0, 54);
        test_random_traffic(225, 34, 34);

        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);

        if (predicted_replies.size() != 0)
            report_mismatch("results still expected at end",
                            DATA_W'(predicted_replies.size()), '0);
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 sent_count, checked_count, errors);
        $display("overflows %0d, underflows %0d, peak fill %0d of %0d",
                 overflow_count, underflow_count, peak_fill, DEPTH);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
